// ----- src/wsg_pkg.sv -----
package wsg_pkg;

    // action codes
    localparam logic [1:0] ACT_CLEAR   = 2'd0;
    localparam logic [1:0] ACT_APPEND  = 2'd1;
    localparam logic [1:0] ACT_SUBJECT = 2'd2;
    localparam logic [1:0] ACT_END     = 2'd3;

    localparam logic [7:0] STAR_BYTE = 8'h2A;

    localparam int MAX_PATTERN_DEF = 32;
    localparam int QUEUE_DEPTH     = 2;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] byte_value;
    } t_in_word;

    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } t_out_word;

    // classified word as held in the queue
    typedef struct packed {
        logic [1:0] action;
        logic [7:0] byte_value;
        logic       is_star;
    } t_cmd;

endpackage

// ----- src/wildcard_star_glob_matcher.sv -----
// Glob matcher with '*' wildcards. Load a pattern one append word at a time
// (clear empties it), then stream the subject one subject word at a time and
// close it with an end word, which yields one result word: matched, and
// whether pattern bytes were dropped past MAX_PATTERN (matched then reads 0).
// Sustained rate is one word per cycle of any action, unless an end word
// waits on a stalled result; the active set of pattern positions is updated
// for each word popped, with star closure done by one MAX_PATTERN+2 bit carry
// chain in the back end. A result word is registered: its end word passes
// through the queue register and, as it leaves the queue, its result is
// loaded straight into the output register. Clear, append and subject words
// never wait on the output side. An end word waits at the head of the
// two-word queue while an earlier result is still stalled, and the input
// stalls once that end word and one more word have filled the queue.
module wildcard_star_glob_matcher #(
    parameter int MAX_PATTERN = wsg_pkg::MAX_PATTERN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  wsg_pkg::t_in_word  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output wsg_pkg::t_out_word o_out
);

    logic          q_valid;
    logic          q_pop;
    wsg_pkg::t_cmd q_cmd;

    // front: classify and queue
    wsg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_q_valid  (q_valid),
        .o_q_cmd    (q_cmd),
        .i_q_pop    (q_pop)
    );

    // back: pattern store, active set, result register
    wsg_back #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    // a match is never reported alongside a dropped pattern byte
    a_match_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out.matched && o_out.pattern_overflow))
        else $error("match reported with pattern overflow");

    // a full queue stays full until the back end pops
    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_stall && !q_pop) |=> o_in_stall)
        else $error("queue lost a word");

    // a new result only follows an end word leaving the queue
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(q_pop && (q_cmd.action == wsg_pkg::ACT_END)))
        else $error("result without end word");

    // nothing is offered straight after reset
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

// ----- src/wsg_front.sv -----
module wsg_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  wsg_pkg::t_in_word i_in,
    output logic             o_q_valid,
    output wsg_pkg::t_cmd    o_q_cmd,
    input  logic             i_q_pop
);

    localparam int PTR_W = (wsg_pkg::QUEUE_DEPTH > 1) ? $clog2(wsg_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(wsg_pkg::QUEUE_DEPTH + 1);

    wsg_pkg::t_cmd    r_q [wsg_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             push;
    wsg_pkg::t_cmd    cmd;

    assign o_in_stall = (r_cnt == CNT_W'(wsg_pkg::QUEUE_DEPTH));
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_cnt != '0);
    assign o_q_cmd    = r_q[r_rd];

    // classify: flag star bytes once, here
    always_comb begin
        cmd.action     = i_in.action;
        cmd.byte_value = i_in.byte_value;
        cmd.is_star    = (i_in.byte_value == wsg_pkg::STAR_BYTE);
    end

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (push) begin
            n_wr = (r_wr == PTR_W'(wsg_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_q_pop) begin
            n_rd = (r_rd == PTR_W'(wsg_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (push && !i_q_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!push && i_q_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= cmd;
        end
    end

endmodule

// ----- src/wsg_back.sv -----
module wsg_back #(
    parameter int MAX_PATTERN = wsg_pkg::MAX_PATTERN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  wsg_pkg::t_cmd     i_q_cmd,
    output logic              o_q_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output wsg_pkg::t_out_word o_out
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [7:0]             r_pat [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] r_star, n_star;
    logic [LEN_W-1:0]       r_len, n_len;
    logic                   r_ovf, n_ovf;
    logic [MAX_PATTERN:0]   r_act, n_act;
    logic                   r_out_valid;
    wsg_pkg::t_out_word     r_out;

    logic                   room;
    logic                   is_subj;
    logic                   is_end;
    logic                   wr_pat;
    logic [MAX_PATTERN-1:0] live, eq, ss;
    logic [MAX_PATTERN:0]   prop, seed, x, clos, step;
    logic [MAX_PATTERN+1:0] sum;

    assign is_subj = (i_q_cmd.action == wsg_pkg::ACT_SUBJECT);
    assign is_end  = (i_q_cmd.action == wsg_pkg::ACT_END);
    assign o_q_pop = i_q_valid && (!is_end || !r_out_valid || !i_out_stall);
    assign room    = (r_len < LEN_W'(MAX_PATTERN));
    assign wr_pat  = o_q_pop && (i_q_cmd.action == wsg_pkg::ACT_APPEND) && room;

    // pattern registers
    always_comb begin
        n_len  = r_len;
        n_ovf  = r_ovf;
        n_star = r_star;
        if (o_q_pop) begin
            unique case (i_q_cmd.action)
                wsg_pkg::ACT_CLEAR: begin
                    n_len = '0;
                    n_ovf = 1'b0;
                end
                wsg_pkg::ACT_APPEND: begin
                    if (room) begin
                        n_len = r_len + 1'b1;
                        n_star[r_len[IDX_W-1:0]] = i_q_cmd.is_star;
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // per-position terms
    always_comb begin
        prop[0] = 1'b0;
        for (int j = 0; j < MAX_PATTERN; j++) begin
            live[j]   = (LEN_W'(j) < n_len);
            prop[j+1] = n_star[j] && live[j];
            eq[j]     = r_act[j] && live[j] && !r_star[j] &&
                        (r_pat[j] == i_q_cmd.byte_value);
            ss[j]     = r_act[j] && live[j] && r_star[j];
        end
    end

    // star closure as one carry chain: the carry from each seed bit runs
    // through the following star positions and stops at the first non-star
    always_comb begin
        seed = is_subj ? {eq, 1'b0} : (MAX_PATTERN+1)'(1);
        x    = seed | prop;
        sum  = {1'b0, x} + {1'b0, seed};
        clos = (x & ~sum[MAX_PATTERN:0]) | seed;
        step = is_subj ? (clos | {1'b0, ss} | {ss, 1'b0}) : clos;
        n_act = o_q_pop ? step : r_act;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_act       <= (MAX_PATTERN+1)'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_len <= n_len;
            r_ovf <= n_ovf;
            r_act <= n_act;
            if (o_q_pop && is_end) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_star <= n_star;
        if (wr_pat) begin
            r_pat[r_len[IDX_W-1:0]] <= i_q_cmd.byte_value;
        end
        if (o_q_pop && is_end) begin
            r_out.matched          <= r_act[r_len] && !r_ovf;
            r_out.pattern_overflow <= r_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    // Random part length, and how many words before the end run with no idling.
    localparam int RANDOM_WORDS = 1400;
    localparam int CALM_TAIL    = 150;
    localparam int PAT_CAP      = wsg_pkg::MAX_PATTERN_DEF;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    wsg_pkg::t_in_word  i_in        = '0;
    logic               i_out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    wsg_pkg::t_out_word o_out;

    wildcard_star_glob_matcher dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always #2 i_clk = ~i_clk;

    // ---------------------------------------------------------------------
    // Predicted matcher state. Only entries below pat_len are ever read, so
    // the store needs no reset value.
    // ---------------------------------------------------------------------
    logic [7:0]       pat_bytes [PAT_CAP];
    int unsigned      pat_len     = 0;
    logic [PAT_CAP:0] live_pos    = 1;
    bit               pat_dropped = 1'b0;

    // verdicts still owed by the block, oldest first
    wsg_pkg::t_out_word pending_verdicts [$];

    int  n_sent       = 0;
    int  fail_count   = 0;
    bit  sender_idles = 1'b0;
    bit  sink_busy    = 1'b0;
    bit  calm         = 1'b0;
    int  stall_left   = 0;

    // Position zero plus the run of leading stars.
    function automatic void rearm_positions();
        live_pos    = '0;
        live_pos[0] = 1'b1;
        for (int k = 1; k <= pat_len && pat_bytes[k-1] == wsg_pkg::STAR_BYTE; k++)
            live_pos[k] = 1'b1;
    endfunction

    // Applies one word to the predicted state; returns 1 when it yields a verdict.
    function automatic bit glob_step(input wsg_pkg::t_in_word w,
                                     output wsg_pkg::t_out_word verdict);
        logic [PAT_CAP:0] nxt;
        int unsigned      k;
        verdict = '0;
        case (w.action)
            wsg_pkg::ACT_CLEAR: begin
                pat_len     = 0;
                pat_dropped = 1'b0;
                rearm_positions();
                return 1'b0;
            end
            wsg_pkg::ACT_APPEND: begin
                if (pat_len < PAT_CAP) begin
                    pat_bytes[pat_len] = w.byte_value;
                    pat_len++;
                end else begin
                    pat_dropped = 1'b1;
                end
                rearm_positions();
                return 1'b0;
            end
            wsg_pkg::ACT_SUBJECT: begin
                nxt = '0;
                for (int unsigned j = 0; j < pat_len; j++) begin
                    if (live_pos[j]) begin
                        if (pat_bytes[j] == wsg_pkg::STAR_BYTE) begin
                            nxt[j]     = 1'b1;
                            nxt[j + 1] = 1'b1;
                        end else if (pat_bytes[j] == w.byte_value) begin
                            k      = j + 1;
                            nxt[k] = 1'b1;
                            // closure over the stars that follow a literal hit
                            while (k < pat_len && pat_bytes[k] == wsg_pkg::STAR_BYTE) begin
                                k++;
                                nxt[k] = 1'b1;
                            end
                        end
                    end
                end
                live_pos = nxt;
                return 1'b0;
            end
            default: begin
                verdict.matched          = live_pos[pat_len] && !pat_dropped;
                verdict.pattern_overflow = pat_dropped;
                rearm_positions();
                return 1'b1;
            end
        endcase
    endfunction

    // Byte pool biased towards values that make patterns hit.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 5))
            0:       return 8'h61;
            1:       return 8'h62;
            2:       return 8'h00;
            3:       return 8'hFF;
            4:       return wsg_pkg::STAR_BYTE;
            default: return 8'($urandom);
        endcase
    endfunction

    // Present one word from a falling edge and hold it until taken. A typed
    // verdict, where given, replaces the predicted one.
    task automatic send_word(input wsg_pkg::t_in_word w, input bit typed = 1'b0,
                             input wsg_pkg::t_out_word typed_res = '0);
        wsg_pkg::t_out_word verdict;
        if (sender_idles && !calm && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        n_sent++;
        if (glob_step(w, verdict))
            pending_verdicts.push_back(typed ? typed_res : verdict);
        @(negedge i_clk);
    endtask

    // Hold the sender off until every owed verdict has come back.
    task automatic drain_verdicts();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending_verdicts.size() != 0);
    endtask

    // One random job: mostly a pattern load followed by subjects built from
    // it, some near misses, the odd append mid-subject, and pure noise.
    task automatic run_job();
        wsg_pkg::t_in_word w;
        wsg_pkg::t_in_word words [$];
        int                plen;
        calm         = (n_sent >= RANDOM_WORDS - CALM_TAIL);
        sender_idles = ($urandom_range(0, 2) != 0);
        sink_busy    = ($urandom_range(0, 2) != 0);
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) begin
                w.action     = 2'($urandom_range(0, 3));
                w.byte_value = 8'($urandom);
                send_word(w);
            end
            return;
        end
        if ($urandom_range(0, 3) != 0) begin
            w.action     = wsg_pkg::ACT_CLEAR;
            w.byte_value = 8'($urandom);
            send_word(w);
        end
        // now and then a long pattern, to fill the store and spill past it
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 6);
        repeat (plen) begin
            w.action     = wsg_pkg::ACT_APPEND;
            w.byte_value = ($urandom_range(0, 3) == 0) ? wsg_pkg::STAR_BYTE : pick_byte();
            send_word(w);
        end
        repeat ($urandom_range(1, 3)) begin
            words.delete();
            w.action = wsg_pkg::ACT_SUBJECT;
            for (int j = 0; j < pat_len; j++) begin
                if (pat_bytes[j] == wsg_pkg::STAR_BYTE) begin
                    repeat ($urandom_range(0, 3)) begin
                        w.byte_value = pick_byte();
                        words.push_back(w);
                    end
                end else begin
                    w.byte_value = ($urandom_range(0, 11) == 0) ? pick_byte() : pat_bytes[j];
                    words.push_back(w);
                end
            end
            if ($urandom_range(0, 7) == 0) begin
                w.byte_value = pick_byte();
                words.push_back(w);
            end
            if ($urandom_range(0, 7) == 0 && words.size() != 0)
                words.delete($urandom_range(0, words.size() - 1));
            if ($urandom_range(0, 15) == 0) begin
                w.action     = wsg_pkg::ACT_APPEND;
                w.byte_value = pick_byte();
                words.insert($urandom_range(0, words.size()), w);
            end
            w.action     = wsg_pkg::ACT_END;
            w.byte_value = 8'($urandom);
            words.push_back(w);
            foreach (words[i]) send_word(words[i]);
        end
    endtask

    // ---------------------------------------------------------------------
    // Directed words. A typed verdict is given only where it is obvious;
    // the rest are left to the predictor.
    // ---------------------------------------------------------------------
    typedef struct packed {
        logic [1:0] act;
        logic [7:0] val;
        logic       typed;
        logic       matched;
        logic       overflow;
    } t_dir_row;

    localparam t_dir_row DIR_ROWS [25] = '{
        '{wsg_pkg::ACT_END,     8'h00,              1'b1, 1'b1, 1'b0},  // empty, empty
        '{wsg_pkg::ACT_SUBJECT, 8'h61,              1'b0, 1'b0, 1'b0},
        '{wsg_pkg::ACT_END,     8'hFF,              1'b1, 1'b0, 1'b0},  // empty, one byte
        '{wsg_pkg::ACT_APPEND,  wsg_pkg::STAR_BYTE, 1'b0, 1'b0, 1'b0},
        '{wsg_pkg::ACT_END,     8'h55,              1'b1, 1'b1, 1'b0},  // lone star, empty
        '{wsg_pkg::ACT_APPEND,  8'h61,              1'b0, 1'b0, 1'b0},
        '{wsg_pkg::ACT_SUBJECT, 8'h62,              1'b0, 1'b0, 1'b0},
        '{wsg_pkg::ACT_SUBJECT, 8'h61,              1'b0, 1'b0, 1'b0},
        '{wsg_pkg::ACT_END,     8'h00,              1'b0, 1'b0, 1'b0},
        '{wsg_pkg::ACT_CLEAR,   8'hFF,              1'b0, 1'b0, 1'b0},
        '{wsg_pkg::ACT_APPEND,  8'h00,              1'b0, 1'b0, 1'b0},  // zero literal
        '{wsg_pkg::ACT_APPEND,  8'hFF,              1'b0, 1'b0, 1'b0},
        '{wsg_pkg::ACT_SUBJECT, 8'h00,              1'b0, 1'b0, 1'b0},
        '{wsg_pkg::ACT_SUBJECT, 8'hFF,              1'b0, 1'b0, 1'b0},
        '{wsg_pkg::ACT_END,     8'hAA,              1'b0, 1'b0, 1'b0},
        '{wsg_pkg::ACT_SUBJECT, 8'h00,              1'b0, 1'b0, 1'b0},
        '{wsg_pkg::ACT_APPEND,  wsg_pkg::STAR_BYTE, 1'b0, 1'b0, 1'b0},  // restarts subject
        '{wsg_pkg::ACT_SUBJECT, 8'h00,              1'b0, 1'b0, 1'b0},
        '{wsg_pkg::ACT_SUBJECT, 8'hFF,              1'b0, 1'b0, 1'b0},
        '{wsg_pkg::ACT_SUBJECT, wsg_pkg::STAR_BYTE, 1'b0, 1'b0, 1'b0},  // 0x2A into star
        '{wsg_pkg::ACT_END,     8'h00,              1'b0, 1'b0, 1'b0},
        '{wsg_pkg::ACT_SUBJECT, 8'hFF,              1'b0, 1'b0, 1'b0},  // 0xFF vs 0x00
        '{wsg_pkg::ACT_END,     8'hFF,              1'b0, 1'b0, 1'b0},
        '{wsg_pkg::ACT_CLEAR,   8'h00,              1'b0, 1'b0, 1'b0},
        '{wsg_pkg::ACT_END,     8'h00,              1'b1, 1'b1, 1'b0}   // cleared, empty
    };

    // Result side: stall in bursts; no new burst starts in the calm tail.
    always @(negedge i_clk) begin
        if (stall_left == 0 && sink_busy && !calm && $urandom_range(0, 4) == 0)
            stall_left = $urandom_range(1, 8);
        i_out_stall <= (stall_left != 0);
        if (stall_left != 0)
            stall_left--;
    end

    // Compare every accepted result word with the oldest owed verdict.
    always @(posedge i_clk) begin : check_words
        wsg_pkg::t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t ns: result word %b with no verdict owed", $time, o_out);
                fail_count++;
            end else begin
                want = pending_verdicts.pop_front();
                if (o_out.matched !== want.matched) begin
                    $display("%0t ns: matched expected %0b actual %0b",
                             $time, want.matched, o_out.matched);
                    fail_count++;
                end
                if (o_out.pattern_overflow !== want.pattern_overflow) begin
                    $display("%0t ns: pattern_overflow expected %0b actual %0b",
                             $time, want.pattern_overflow, o_out.pattern_overflow);
                    fail_count++;
                end
            end
        end
    end

    initial begin : stimulus
        wsg_pkg::t_in_word  w;
        wsg_pkg::t_out_word typed_res;
        bit                 paused = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (DIR_ROWS[i]) begin
            w.action                   = DIR_ROWS[i].act;
            w.byte_value               = DIR_ROWS[i].val;
            typed_res.matched          = DIR_ROWS[i].matched;
            typed_res.pattern_overflow = DIR_ROWS[i].overflow;
            send_word(w, DIR_ROWS[i].typed, typed_res);
        end
        drain_verdicts();

        n_sent = 0;
        while (n_sent < RANDOM_WORDS) begin
            if (!paused && n_sent >= RANDOM_WORDS / 2) begin
                drain_verdicts();
                paused = 1'b1;
            end
            run_job();
        end

        // wait for every owed verdict, then catch any stray result word
        i_in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (fail_count == 0)
            $display("wildcard_star_glob_matcher: match");
        else
            $display("wildcard_star_glob_matcher: mismatch");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("wildcard_star_glob_matcher: mismatch");
        $finish;
    end

endmodule
